// ----- design/xbrm_pkg.sv -----
// Package for the XOR banked ROM window mapper.
// Widths, bank XOR masks and the request/response types of the remainder unit.
// No dependencies.
package xbrm_pkg;

  localparam int ADDR_W     = 16;
  localparam int DATA_W     = 8;
  localparam int CFG_W      = 22;
  localparam int ROM_ADDR_W = 21;
  localparam int OFFS_W     = 13;
  localparam int PAGES_W    = 9;
  localparam int NUM_BANKS  = 4;
  localparam int BANK_IDX_W = 2;
  localparam int CNT_W      = 5;

  localparam logic [CFG_W-1:0]  ROM_SIZE_MAX   = 22'h200000;
  localparam logic [ADDR_W-1:0] BANK_LOAD_ADDR = 16'h2000;

  // last step index of each remainder pass (page pass: 8 bits, address pass: 21 bits)
  localparam logic [CNT_W-1:0] PAGE_LAST = 5'd7;
  localparam logic [CNT_W-1:0] PHYS_LAST = 5'd20;

  // XOR masks applied to the written byte for each window bank
  localparam logic [DATA_W-1:0] BANK_XOR [NUM_BANKS] = '{8'h1F, 8'h1E, 8'h1D, 8'h1C};

  typedef struct packed {
    logic                  start;
    logic [ROM_ADDR_W-1:0] dividend;
    logic [CFG_W-1:0]      divisor;
    logic [CNT_W-1:0]      last;
  } rem_req_t;

  typedef struct packed {
    logic                  busy;
    logic                  done;
    logic [ROM_ADDR_W-1:0] rem;
  } rem_rsp_t;

endpackage

// ----- design/xbrm_ifs.sv -----
// Channel interfaces of the mapper: CPU access items, ROM address results
// and the ROM size write port. Depends on xbrm_pkg.
interface xbrm_in_if;
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic [xbrm_pkg::ADDR_W-1:0]   address;
  logic [xbrm_pkg::DATA_W-1:0]   write_data;

  modport source (output valid, action, address, write_data, input ready);
  modport sink   (input valid, action, address, write_data, output ready);
endinterface

interface xbrm_out_if;
  logic                            valid;
  logic                            ready;
  logic [xbrm_pkg::ROM_ADDR_W-1:0] rom_address;
  logic                            rom_valid;

  modport source (output valid, rom_address, rom_valid, input ready);
  modport sink   (input valid, rom_address, rom_valid, output ready);
endinterface

interface xbrm_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [xbrm_pkg::CFG_W-1:0] rom_size;

  modport source (output valid, rom_size, input ready);
  modport sink   (input valid, rom_size, output ready);
endinterface

// ----- design/xor_banked_rom_window_mapper_unit.sv -----
// Top level of the XOR banked ROM window mapper: sequencer, bank file,
// shared remainder unit and output register. Depends on xbrm_pkg, xbrm_ifs,
// xbrm_bank_file and xbrm_rem_unit.
//
// Usage:
//   in_chan  - CPU access items (action, address, write_data), valid/ready.
//   out_chan - one result per item: rom_address and rom_valid, valid/ready.
//   cfg_chan - ROM size in bytes; always ready, values above 2 MiB saturate.
//              Write it only while no item is in flight.
// A write to 0x2000 reloads all four window banks. Writes, reads at 0xC000
// and above, and reads with no ROM give rom_valid = 0, rom_address = 0.
// A write or flagged read goes from S_IDLE through S_FIN to the output register;
// a mapped read first passes S_PAGE and S_PHYS, which run the one-bit-per-cycle
// remainder unit (8 steps for the page, 21 steps for the byte address).
// One item is in work at a time; in_chan.ready is high only between items.
// A finished result waits in the output register while the next item is taken;
// if the receiver stalls, the following result holds until the register frees.
// Reset clears banks, ROM size (no ROM), the sequencer and the output valid.
module xor_banked_rom_window_mapper_unit (
  input  logic        clk,
  input  logic        rst_n,
  xbrm_in_if.sink     in_chan,
  xbrm_out_if.source  out_chan,
  xbrm_cfg_if.sink    cfg_chan
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PAGE = 2'd1;
  localparam logic [1:0] S_PHYS = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]                          state_r, state_nxt;
  logic [xbrm_pkg::CFG_W-1:0]          rom_size_r;
  logic [xbrm_pkg::OFFS_W-1:0]         offset_r, offset_nxt;
  logic [xbrm_pkg::ROM_ADDR_W-1:0]     res_addr_r, res_addr_nxt;
  logic                                res_vld_r, res_vld_nxt;
  logic [xbrm_pkg::ROM_ADDR_W-1:0]     out_addr_r, out_addr_nxt;
  logic                                out_vld_r, out_vld_nxt;
  logic                                out_valid_r, out_valid_nxt;

  logic                                accept;
  logic                                rd_ok;
  logic                                bank_load;
  logic [xbrm_pkg::BANK_IDX_W-1:0]     bank_idx;
  logic [xbrm_pkg::DATA_W-1:0]         bank_q;
  logic [xbrm_pkg::DATA_W-1:0]         page;
  logic [xbrm_pkg::PAGES_W-1:0]        pages;
  logic [2:0]                          win;
  xbrm_pkg::rem_req_t                  rem_req;
  xbrm_pkg::rem_rsp_t                  rem_rsp;

  // ROM size register, saturating
  assign cfg_chan.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_size_r <= '0;
    end else if (cfg_chan.valid) begin
      rom_size_r <= (cfg_chan.rom_size > xbrm_pkg::ROM_SIZE_MAX) ?
                    xbrm_pkg::ROM_SIZE_MAX : cfg_chan.rom_size;
    end
  end

  // page count, rounded up
  assign pages = rom_size_r[xbrm_pkg::CFG_W-1:xbrm_pkg::OFFS_W]
               + xbrm_pkg::PAGES_W'(|rom_size_r[xbrm_pkg::OFFS_W-1:0]);

  assign in_chan.ready = (state_r == S_IDLE);
  assign accept        = in_chan.valid && in_chan.ready;

  // window decode
  assign win       = in_chan.address[xbrm_pkg::ADDR_W-1:xbrm_pkg::OFFS_W];
  assign bank_idx  = xbrm_pkg::BANK_IDX_W'(win - 3'd2);
  assign bank_load = accept && in_chan.action && (in_chan.address == xbrm_pkg::BANK_LOAD_ADDR);
  assign rd_ok     = !in_chan.action && (rom_size_r != '0) && (win[2:1] != 2'b11);
  assign page      = (win[2:1] == 2'b00) ? xbrm_pkg::DATA_W'(win[0]) : bank_q;

  xbrm_bank_file u_banks (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (bank_load),
    .load_data (in_chan.write_data),
    .rd_idx    (bank_idx),
    .rd_bank   (bank_q)
  );

  xbrm_rem_unit u_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (rem_req),
    .rsp   (rem_rsp)
  );

  // remainder unit requests: page mod pages, then byte address mod rom size
  always_comb begin
    rem_req = '0;
    if (state_r == S_IDLE && accept && rd_ok) begin
      rem_req.start    = 1'b1;
      rem_req.dividend = {page, {xbrm_pkg::OFFS_W{1'b0}}};
      rem_req.divisor  = xbrm_pkg::CFG_W'(pages);
      rem_req.last     = xbrm_pkg::PAGE_LAST;
    end else if (state_r == S_PAGE && rem_rsp.done) begin
      rem_req.start    = 1'b1;
      rem_req.dividend = {rem_rsp.rem[xbrm_pkg::DATA_W-1:0], offset_r};
      rem_req.divisor  = rom_size_r;
      rem_req.last     = xbrm_pkg::PHYS_LAST;
    end
  end

  // sequencer and output register
  always_comb begin
    state_nxt     = state_r;
    offset_nxt    = offset_r;
    res_addr_nxt  = res_addr_r;
    res_vld_nxt   = res_vld_r;
    out_addr_nxt  = out_addr_r;
    out_vld_nxt   = out_vld_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_chan.ready) out_valid_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          offset_nxt   = in_chan.address[xbrm_pkg::OFFS_W-1:0];
          res_addr_nxt = '0;
          res_vld_nxt  = 1'b0;
          state_nxt    = rd_ok ? S_PAGE : S_FIN;
        end
      end
      S_PAGE: begin
        if (rem_rsp.done) state_nxt = S_PHYS;
      end
      S_PHYS: begin
        if (rem_rsp.done) begin
          res_addr_nxt = rem_rsp.rem;
          res_vld_nxt  = 1'b1;
          state_nxt    = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_chan.ready) begin
          out_addr_nxt  = res_addr_r;
          out_vld_nxt   = res_vld_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    offset_r   <= offset_nxt;
    res_addr_r <= res_addr_nxt;
    res_vld_r  <= res_vld_nxt;
    out_addr_r <= out_addr_nxt;
    out_vld_r  <= out_vld_nxt;
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.rom_address = out_addr_r;
  assign out_chan.rom_valid   = out_vld_r;

  // remainder unit is never busy between items
  a_rem_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !rem_rsp.busy)
    else $error("remainder unit busy while sequencer idle");

  // reduced page stays inside the ROM page count
  a_page_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PAGE && rem_rsp.done |-> xbrm_pkg::CFG_W'(rem_rsp.rem) < xbrm_pkg::CFG_W'(pages))
    else $error("page remainder out of range");

  // final byte address lies inside the ROM
  a_phys_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PHYS && rem_rsp.done |-> xbrm_pkg::CFG_W'(rem_rsp.rem) < rom_size_r)
    else $error("ROM address beyond ROM size");

  // a valid ROM read never appears without a ROM
  a_no_rom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_vld_r |-> rom_size_r != '0)
    else $error("ROM read flagged valid with no ROM");

endmodule

// ----- design/xbrm_bank_file.sv -----
// Four window bank registers, loaded together from one byte with per-bank XOR.
// Depends on xbrm_pkg.
module xbrm_bank_file (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              load,
  input  logic [xbrm_pkg::DATA_W-1:0]       load_data,
  input  logic [xbrm_pkg::BANK_IDX_W-1:0]   rd_idx,
  output logic [xbrm_pkg::DATA_W-1:0]       rd_bank
);

  logic [xbrm_pkg::DATA_W-1:0] bank_r [xbrm_pkg::NUM_BANKS];

  // all banks load at once
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < xbrm_pkg::NUM_BANKS; i++) bank_r[i] <= '0;
    end else if (load) begin
      for (int i = 0; i < xbrm_pkg::NUM_BANKS; i++) begin
        bank_r[i] <= load_data ^ xbrm_pkg::BANK_XOR[i];
      end
    end
  end

  assign rd_bank = bank_r[rd_idx];

endmodule

// ----- design/xbrm_rem_unit.sv -----
// Shared restoring remainder unit: one dividend bit per cycle, MSB first.
// Used for both the page reduction and the byte address reduction. Depends on xbrm_pkg.
module xbrm_rem_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  xbrm_pkg::rem_req_t req,
  output xbrm_pkg::rem_rsp_t rsp
);

  logic                              busy_r, busy_nxt;
  logic                              done_r, done_nxt;
  logic [xbrm_pkg::CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [xbrm_pkg::ROM_ADDR_W-1:0]   dvd_r, dvd_nxt;
  logic [xbrm_pkg::CFG_W-1:0]        div_r, div_nxt;
  logic [xbrm_pkg::CFG_W-1:0]        rem_r, rem_nxt;
  logic [xbrm_pkg::CFG_W-1:0]        shifted;

  // partial remainder stays below the divisor, so bit 21 of rem_r is always clear
  assign shifted = {rem_r[xbrm_pkg::CFG_W-2:0], dvd_r[xbrm_pkg::ROM_ADDR_W-1]};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = req.last;
      dvd_nxt  = req.dividend;
      div_nxt  = req.divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      // one compare-and-subtract step
      rem_nxt = (shifted >= div_r) ? shifted - div_r : shifted;
      dvd_nxt = {dvd_r[xbrm_pkg::ROM_ADDR_W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    dvd_r <= dvd_nxt;
    div_r <= div_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.rem  = rem_r[xbrm_pkg::ROM_ADDR_W-1:0];

endmodule
